### rtl/lred_pkg.sv
// Shared types, constants and tables for the line ring escape direction block.
// Used by every module under rtl; depends on nothing else.
package lred_pkg;

  localparam int SENSOR_COUNT = 12;
  localparam int IDX_W        = 4;   // sensor index 0..11
  localparam int RUN_SLOTS    = 6;   // most runs twelve sensors can form
  localparam int COUNT_W      = 3;   // run count 0..6
  localparam int MID_W        = 10;  // run midpoint, -345..150, signed
  localparam int DIFF_W       = 11;  // midpoint difference, signed
  localparam int SUM_W        = 13;  // midpoint sum and angle, signed
  localparam int MAG_W        = 12;  // magnitude of the sum, at most 2070
  localparam int RECIP_W      = 17;  // reciprocal of the run count
  localparam int RECIP_SHIFT  = 16;
  localparam int PROD_W       = MAG_W + RECIP_W;
  localparam int ANGLE_W      = 9;

  localparam int ANGLE_BASE    = -15;  // angle of sensor 0
  localparam int ANGLE_STEP    = 15;   // half the sensor spacing
  localparam int HALF_TURN     = 180;
  localparam int FULL_TURN     = 360;
  localparam int NO_LINE_ANGLE = 180;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  // Port bit of each sensor, sensor 0 first.
  localparam logic [4:0] SENSOR_BIT [SENSOR_COUNT] = '{
    5'd17, 5'd19, 5'd30, 5'd20, 5'd22, 5'd24, 5'd27, 5'd3, 5'd7, 5'd11, 5'd13, 5'd15
  };

  // One classified sample: white flags in scan order and the scan origin.
  typedef struct packed {
    logic [SENSOR_COUNT-1:0] rot;
    logic [IDX_W-1:0]        first_dark;
  } lred_entry_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] escape_angle;
    logic               line_seen;
    logic [COUNT_W-1:0] run_count;
  } lred_result_t;

  // ceil(2^16 / count), exact for magnitudes below 4096.
  function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      3'd1:    r = 17'd65536;
      3'd2:    r = 17'd32768;
      3'd3:    r = 17'd21846;
      3'd4:    r = 17'd16384;
      3'd5:    r = 17'd13108;
      3'd6:    r = 17'd10923;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/line_ring_escape_direction.sv
// Top level of the line ring escape direction block.
// Depends on lred_pkg, lred_front, lred_queue and lred_back.
//
// Reads twelve low-active ring sensors out of a 32-bit port sample, finds
// the runs of white sensors around the ring and turns their midpoints into
// one escape direction, 0..359 degrees (180 with line_seen low when no
// sensor is white). Up to MAX_RUNS runs are kept in scan order and
// run_count saturates there. The block takes one sample every clock cycle
// while the output is not stalled and returns exactly one result per
// sample, in order. An accepted sample is written into the four-entry
// queue behind the classifier, then passes the three back stages (run
// endpoints, midpoint sum, reciprocal multiply) and the output register.
// Throughput is set by the back pipeline, advancing one stage per cycle
// unless the output stalls; the queue and output register let either side
// stall on its own.
module line_ring_escape_direction #(
  parameter int MAX_RUNS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] port_level
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [8:0] escape_angle, [9] line_seen, [12:10] run_count
);

  lred_pkg::lred_entry_t  front_entry;
  lred_pkg::lred_entry_t  queue_entry;
  lred_pkg::lred_result_t result;
  logic                   queue_valid;
  logic                   back_ready;

  // Classify the incoming sample: white flags in scan order.
  lred_front u_front (
    .port_level (s_tdata),
    .entry      (front_entry)
  );

  // Hold classified samples until the back pipeline can take them.
  lred_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_entry (front_entry),
    .pop_valid  (queue_valid),
    .pop_ready  (back_ready),
    .pop_entry  (queue_entry)
  );

  // Extract runs, average midpoints, wrap, and register the result.
  lred_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (queue_valid),
    .in_ready   (back_ready),
    .in_entry   (queue_entry),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {3'b000, result.run_count, result.line_seen, result.escape_angle};

  // No line seen: fixed angle and no runs.
  a_no_line: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !result.line_seen) |->
      (result.escape_angle == 9'd180 && result.run_count == 3'd0))
    else $error("no-line result carries a stray angle or run count");

  // Line seen: angle wrapped into range and count within the cap.
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.line_seen) |->
      (result.escape_angle < 9'd360 && result.run_count != 3'd0
       && result.run_count <= 3'(MAX_RUNS)))
    else $error("line result out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

### rtl/lred_front.sv
// Front classifier: extracts the twelve white flags from a port sample and
// rotates them so the scan starts at the first dark sensor. Uses lred_pkg.
module lred_front (
  input  logic [31:0]          port_level,
  output lred_pkg::lred_entry_t entry
);

  logic [lred_pkg::SENSOR_COUNT-1:0] white;
  logic [lred_pkg::IDX_W-1:0]        first_dark;
  logic                              found;
  logic [lred_pkg::IDX_W:0]          idx;

  always_comb begin
    for (int k = 0; k < lred_pkg::SENSOR_COUNT; k++) begin
      white[k] = ~port_level[lred_pkg::SENSOR_BIT[k]];
    end
    // Lowest dark sensor; sensor 0 when all are white.
    first_dark = '0;
    found      = 1'b0;
    for (int k = 0; k < lred_pkg::SENSOR_COUNT; k++) begin
      if (!white[k] && !found) begin
        first_dark = lred_pkg::IDX_W'(k);
        found      = 1'b1;
      end
    end
    idx = '0;
    for (int k = 0; k < lred_pkg::SENSOR_COUNT; k++) begin
      idx = {1'b0, first_dark} + (lred_pkg::IDX_W + 1)'(k);
      if (idx >= (lred_pkg::IDX_W + 1)'(lred_pkg::SENSOR_COUNT)) begin
        idx = idx - (lred_pkg::IDX_W + 1)'(lred_pkg::SENSOR_COUNT);
      end
      entry.rot[k] = white[idx[lred_pkg::IDX_W-1:0]];
    end
    entry.first_dark = first_dark;
  end

endmodule

### rtl/lred_queue.sv
// Short queue between the front classifier and the back pipeline.
// Holds lred_pkg::lred_entry_t items; depth from lred_pkg.
module lred_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  lred_pkg::lred_entry_t push_entry,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output lred_pkg::lred_entry_t pop_entry
);

  lred_pkg::lred_entry_t            mem [lred_pkg::QUEUE_DEPTH];
  logic [lred_pkg::PTR_W-1:0]       wr_ptr;
  logic [lred_pkg::PTR_W-1:0]       rd_ptr;
  logic [lred_pkg::LEVEL_W-1:0]     level;
  logic                             push;
  logic                             pop;

  assign push_ready = level != lred_pkg::LEVEL_W'(lred_pkg::QUEUE_DEPTH);
  assign pop_valid  = level != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

endmodule

### rtl/lred_back.sv
// Back pipeline: run extraction, midpoints, averaging and wrap in four
// registered stages, the last being the output register. Uses lred_pkg.
module lred_back #(
  parameter int MAX_RUNS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lred_pkg::lred_entry_t  in_entry,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lred_pkg::lred_result_t out_result
);

  localparam int N  = lred_pkg::SENSOR_COUNT;
  localparam int RS = lred_pkg::RUN_SLOTS;
  localparam int IW = lred_pkg::IDX_W;
  localparam int CW = lred_pkg::COUNT_W;

  // stage valids and advance chain
  logic vb, vc, vd;
  logic adv_b, adv_c, adv_d, adv_e;

  assign adv_e    = !out_valid || out_ready;
  assign adv_d    = !vd || adv_e;
  assign adv_c    = !vc || adv_d;
  assign adv_b    = !vb || adv_c;
  assign in_ready = adv_b;

  // ---------------- stage B: run endpoints ----------------
  logic [N-1:0]    sf, ef;
  logic [CW-1:0]   srank [N];
  logic [CW-1:0]   erank [N];
  logic [IW-1:0]   s_rot [RS];
  logic [IW-1:0]   e_rot [RS];
  logic [IW:0]     s_abs, e_abs;
  logic [CW-1:0]   total;
  logic [CW-1:0]   count_b_next;
  logic [IW-1:0]   s_idx_next [RS];
  logic [IW-1:0]   e_idx_next [RS];
  logic [RS-1:0]   keep_next;

  logic [IW-1:0]   s_idx [RS];
  logic [IW-1:0]   e_idx [RS];
  logic [RS-1:0]   keep;
  logic [CW-1:0]   count_b;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      sf[k] = in_entry.rot[k] && ((k == 0) || !in_entry.rot[(k + N - 1) % N]);
      ef[k] = in_entry.rot[k] && ((k == N - 1) || !in_entry.rot[(k + 1) % N]);
      srank[k] = CW'($countones(sf & ((N'(1) << k) - N'(1))));
      erank[k] = CW'($countones(ef & ((N'(1) << k) - N'(1))));
    end
    total = CW'($countones(sf));
    count_b_next = (total > CW'(MAX_RUNS)) ? CW'(MAX_RUNS) : total;
    s_abs = '0;
    e_abs = '0;
    for (int i = 0; i < RS; i++) begin
      s_rot[i] = '0;
      e_rot[i] = '0;
      for (int k = 0; k < N; k++) begin
        if (sf[k] && srank[k] == CW'(i)) s_rot[i] = IW'(k);
        if (ef[k] && erank[k] == CW'(i)) e_rot[i] = IW'(k);
      end
      // map scan position back to sensor index
      s_abs = {1'b0, in_entry.first_dark} + {1'b0, s_rot[i]};
      if (s_abs >= (IW + 1)'(N)) s_abs = s_abs - (IW + 1)'(N);
      e_abs = {1'b0, in_entry.first_dark} + {1'b0, e_rot[i]};
      if (e_abs >= (IW + 1)'(N)) e_abs = e_abs - (IW + 1)'(N);
      s_idx_next[i] = s_abs[IW-1:0];
      e_idx_next[i] = e_abs[IW-1:0];
      keep_next[i]  = CW'(i) < count_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv_b) begin
      vb <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      s_idx   <= s_idx_next;
      e_idx   <= e_idx_next;
      keep    <= keep_next;
      count_b <= count_b_next;
    end
  end

  // ---------------- stage C: midpoints and sum ----------------
  logic        [IW:0]                  idx_sum;
  logic        [8:0]                   scaled;
  logic signed [lred_pkg::MID_W-1:0]   mid [RS];
  logic signed [lred_pkg::DIFF_W-1:0]  diff;
  logic signed [lred_pkg::SUM_W-1:0]   sum_next;
  logic                                sub_next;

  logic signed [lred_pkg::SUM_W-1:0]   sum_c;
  logic                                sub_c;
  logic        [CW-1:0]                count_c;

  always_comb begin
    idx_sum  = '0;
    scaled   = '0;
    sum_next = '0;
    for (int i = 0; i < RS; i++) begin
      idx_sum = {1'b0, s_idx[i]} + {1'b0, e_idx[i]};
      scaled  = 9'(idx_sum) * 9'(lred_pkg::ANGLE_STEP);
      if (!keep[i]) begin
        mid[i] = '0;
      end else if (s_idx[i] > e_idx[i]) begin
        // run wraps past sensor 11: start angle lifted by a full turn
        mid[i] = lred_pkg::MID_W'(lred_pkg::HALF_TURN + lred_pkg::ANGLE_BASE)
                 - $signed({1'b0, scaled});
      end else begin
        mid[i] = lred_pkg::MID_W'(lred_pkg::ANGLE_BASE) - $signed({1'b0, scaled});
      end
      sum_next = sum_next + lred_pkg::SUM_W'(mid[i]);
    end
    diff     = lred_pkg::DIFF_W'(mid[0]) - lred_pkg::DIFF_W'(mid[1]);
    sub_next = (count_b == CW'(2)) && (diff > $signed(lred_pkg::DIFF_W'(lred_pkg::HALF_TURN)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      sum_c   <= sum_next;
      sub_c   <= sub_next;
      count_c <= count_b;
    end
  end

  // ---------------- stage D: divide by count ----------------
  logic [lred_pkg::SUM_W-1:0]  abs_sum;
  logic [lred_pkg::PROD_W-1:0] prod_next;

  logic [lred_pkg::PROD_W-1:0] prod_d;
  logic                        neg_d;
  logic                        sub_d;
  logic [CW-1:0]               count_d;

  always_comb begin
    abs_sum   = sum_c[lred_pkg::SUM_W-1] ? lred_pkg::SUM_W'(-sum_c) : lred_pkg::SUM_W'(sum_c);
    prod_next = lred_pkg::PROD_W'(abs_sum[lred_pkg::MAG_W-1:0])
                * lred_pkg::PROD_W'(lred_pkg::recip(count_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv_d) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_d) begin
      prod_d  <= prod_next;
      neg_d   <= sum_c[lred_pkg::SUM_W-1];
      sub_d   <= sub_c;
      count_d <= count_c;
    end
  end

  // ---------------- stage E: sign, offset, wrap ----------------
  logic        [lred_pkg::MAG_W-1:0] quot;
  logic signed [lred_pkg::SUM_W-1:0] esc;
  lred_pkg::lred_result_t            result_next;

  always_comb begin
    quot = prod_d[lred_pkg::RECIP_SHIFT +: lred_pkg::MAG_W];
    esc  = $signed(lred_pkg::SUM_W'({1'b0, quot}));
    if (neg_d) esc = -esc;
    if (sub_d) esc = esc - lred_pkg::SUM_W'(lred_pkg::HALF_TURN);
    if (esc >= $signed(lred_pkg::SUM_W'(lred_pkg::FULL_TURN)))
      esc = esc - lred_pkg::SUM_W'(lred_pkg::FULL_TURN);
    if (esc < 0) esc = esc + lred_pkg::SUM_W'(lred_pkg::FULL_TURN);
    if (esc < 0) esc = esc + lred_pkg::SUM_W'(lred_pkg::FULL_TURN);
    if (count_d == '0) begin
      result_next.escape_angle = lred_pkg::ANGLE_W'(lred_pkg::NO_LINE_ANGLE);
      result_next.line_seen    = 1'b0;
    end else begin
      result_next.escape_angle = esc[lred_pkg::ANGLE_W-1:0];
      result_next.line_seen    = 1'b1;
    end
    result_next.run_count = count_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_e) begin
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_e) out_result <= result_next;
  end

endmodule
